/* rtl/dhed_pkg.sv */
// Shared types and constants for the drum hit envelope detector.
`timescale 1ns / 1ps

package dhed_pkg;

  localparam int DRUM_BITS     = 2;
  localparam int TIME_BITS     = 32;
  localparam int FRAC_BITS     = 8;
  localparam int RATE_BITS     = 16;
  localparam int THR_BITS      = 12;
  localparam int REFR_BITS     = 16;
  localparam int SETTING_BITS  = THR_BITS + REFR_BITS;
  localparam int ENV_OUT_BITS  = 12;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = SETTING_BITS;

  localparam logic [RATE_BITS-1:0]    DC_RATE_RESET  = 16'd66;
  localparam logic [RATE_BITS-1:0]    ENV_RATE_RESET = 16'd3277;
  // threshold 400, refractory 80 ms
  localparam logic [SETTING_BITS-1:0] SETTING_RESET  = 28'd328080;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_DC_RATE  = 3'd0,
    REG_ENV_RATE = 3'd1,
    REG_DRUM0    = 3'd2,
    REG_DRUM1    = 3'd3,
    REG_DRUM2    = 3'd4,
    REG_DRUM3    = 3'd5
  } cfg_reg_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DC   = 6'b000010,
    S_DCU  = 6'b000100,
    S_ENV  = 6'b001000,
    S_ENVU = 6'b010000,
    S_DONE = 6'b100000
  } seq_state_t;

  // channel state write-back control
  typedef struct packed {
    logic we;
    logic hit;
  } chan_wr_t;

endpackage

/* rtl/dhed_if.sv */
// Valid/ready channel interfaces for sample items and result items.
`timescale 1ns / 1ps

interface dhed_in_if #(
  parameter int SAMPLE_BITS = 12
);
  import dhed_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [DRUM_BITS-1:0]   drum;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   time_ms;
  logic                   force_hit;

  modport source (output valid, drum, sample, time_ms, force_hit, input ready);
  modport sink   (input valid, drum, sample, time_ms, force_hit, output ready);
endinterface

interface dhed_out_if;
  import dhed_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DRUM_BITS-1:0]    drum_out;
  logic [ENV_OUT_BITS-1:0] envelope_level;
  logic                    hit;

  modport source (output valid, drum_out, envelope_level, hit, input ready);
  modport sink   (input valid, drum_out, envelope_level, hit, output ready);
endinterface

/* rtl/dhed_pole_unit.sv */
// Shared one-pole filter step unit: magnitude, Q0.16 multiply, step apply.
`timescale 1ns / 1ps

module dhed_pole_unit import dhed_pkg::*; #(
  parameter int LW = 20
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [LW-1:0]        x,
  input  logic [LW-1:0]        y,
  input  logic [RATE_BITS-1:0] rate,
  output logic [LW-1:0]        res
);

  logic [LW-1:0]           mag;
  logic                    up;
  logic [RATE_BITS+LW-1:0] prod;
  logic [LW-1:0]           delta_r;
  logic [LW-1:0]           y_r;
  logic                    up_r;

  assign up   = (x >= y);
  assign mag  = up ? (x - y) : (y - x);
  assign prod = (RATE_BITS+LW)'(rate) * (RATE_BITS+LW)'(mag);

  always_ff @(posedge clk) begin
    if (load) begin
      delta_r <= prod[RATE_BITS+LW-1:RATE_BITS];
      y_r     <= y;
      up_r    <= up;
    end
  end

  // step never exceeds |x - y|, so no wrap
  assign res = up_r ? (y_r + delta_r) : (y_r - delta_r);

endmodule

/* rtl/dhed_chan_store.sv */
// Per-channel filter levels and last hit timestamps.
`timescale 1ns / 1ps

module dhed_chan_store import dhed_pkg::*; #(
  parameter int LW         = 20,
  parameter int DRUM_COUNT = 4,
  parameter int IW         = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IW-1:0]        rd_idx,
  output logic [LW-1:0]        rd_dc,
  output logic [LW-1:0]        rd_loud,
  output logic [TIME_BITS-1:0] rd_last,
  input  chan_wr_t             wr,
  input  logic [IW-1:0]        wr_idx,
  input  logic [LW-1:0]        wr_dc,
  input  logic [LW-1:0]        wr_loud,
  input  logic [TIME_BITS-1:0] wr_time
);

  // mid-scale offset: 2^(SAMPLE_BITS-1) in Q.8
  localparam logic [LW-1:0] DC_RESET = LW'(1) << (LW - 1);

  logic [LW-1:0]        dc_r   [DRUM_COUNT];
  logic [LW-1:0]        loud_r [DRUM_COUNT];
  logic [TIME_BITS-1:0] last_r [DRUM_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DRUM_COUNT; k++) begin
        dc_r[k]   <= DC_RESET;
        loud_r[k] <= '0;
        last_r[k] <= '0;
      end
    end else if (wr.we) begin
      dc_r[wr_idx]   <= wr_dc;
      loud_r[wr_idx] <= wr_loud;
      if (wr.hit) begin
        last_r[wr_idx] <= wr_time;
      end
    end
  end

  assign rd_dc   = dc_r[rd_idx];
  assign rd_loud = loud_r[rd_idx];
  assign rd_last = last_r[rd_idx];

endmodule

/* rtl/drum_hit_envelope_detector_top.sv */
// Top level of the drum hit envelope detector: sequencer, config and output register.
`timescale 1ns / 1ps

//  channel | direction | fields                                    | handshake
//  --------+-----------+-------------------------------------------+------------------
//  in_ch   | sink      | drum, sample, time_ms, force_hit          | valid/ready
//  out_ch  | source    | drum_out, envelope_level, hit             | valid/ready
//  cfg_*   | sink      | cfg_addr, cfg_wdata                       | cfg_we, no stall
//
//  An item goes through the states idle, DC multiply, DC update, envelope multiply,
//  envelope update and result; a channel outside DRUM_COUNT goes from idle to result.
//  The one shared 16 x LW multiplier in dhed_pole_unit serves both filters in turn.
//  in_ch.ready is high only while the sequencer is idle.
//  A finished result waits in the sequencer while out_ch holds an untaken transfer.
//  Synchronous active-low reset: rates, settings and channel state return to defaults.

module drum_hit_envelope_detector_top import dhed_pkg::*; #(
  parameter int DRUM_COUNT  = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  dhed_in_if.sink                  in_ch,
  dhed_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int LW = SAMPLE_BITS + FRAC_BITS;            // level width, Q.8
  localparam int CW = (LW > THR_BITS + FRAC_BITS) ? LW : THR_BITS + FRAC_BITS;
  localparam int IW = (DRUM_COUNT > 1) ? $clog2(DRUM_COUNT) : 1;

  seq_state_t state_r, state_nxt;

  // configuration
  logic [RATE_BITS-1:0]    dc_rate_r;
  logic [RATE_BITS-1:0]    env_rate_r;
  logic [SETTING_BITS-1:0] setting_r [DRUM_COUNT];

  // item under work
  logic [DRUM_BITS-1:0] drum_r;
  logic [IW-1:0]        idx_r;
  logic                 chok_r;
  logic [LW-1:0]        raw_r;
  logic [TIME_BITS-1:0] time_r;
  logic                 force_r;
  logic [LW-1:0]        dc_r;
  logic [LW-1:0]        loud_r;
  logic [LW-1:0]        rect_r;
  logic [TIME_BITS-1:0] last_r;
  logic [THR_BITS-1:0]  thr_r;
  logic [REFR_BITS-1:0] refr_r;
  logic                 hit_r;

  // result register
  logic                    out_valid_r;
  logic [DRUM_BITS-1:0]    out_drum_r;
  logic [ENV_OUT_BITS-1:0] out_env_r;
  logic                    out_hit_r;

  logic                 in_xfer;
  logic                 in_chok;
  logic [IW-1:0]        in_idx;
  logic [LW-1:0]        st_dc;
  logic [LW-1:0]        st_loud;
  logic [TIME_BITS-1:0] st_last;
  logic                 pole_load;
  logic [LW-1:0]        pole_x;
  logic [LW-1:0]        pole_y;
  logic [RATE_BITS-1:0] pole_rate;
  logic [LW-1:0]        pole_res;
  logic                 hit_nxt;
  logic [CW-1:0]        loud_ext;
  logic                 out_load;
  chan_wr_t             wr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_chok     = (int'(in_ch.drum) < DRUM_COUNT);
  // out-of-range channels read entry 0; that data is never used
  assign in_idx      = in_chok ? IW'(in_ch.drum) : '0;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_rate_r  <= DC_RATE_RESET;
      env_rate_r <= ENV_RATE_RESET;
      for (int k = 0; k < DRUM_COUNT; k++) begin
        setting_r[k] <= SETTING_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_addr == REG_DC_RATE) begin
        dc_rate_r <= cfg_wdata[RATE_BITS-1:0];
      end
      if (cfg_addr == REG_ENV_RATE) begin
        env_rate_r <= cfg_wdata[RATE_BITS-1:0];
      end
      for (int k = 0; k < DRUM_COUNT; k++) begin
        if (int'(cfg_addr) == int'(REG_DRUM0) + k) begin
          setting_r[k] <= cfg_wdata[SETTING_BITS-1:0];
        end
      end
    end
  end

  // ---------------- channel state ----------------
  dhed_chan_store #(
    .LW         (LW),
    .DRUM_COUNT (DRUM_COUNT),
    .IW         (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (in_idx),
    .rd_dc   (st_dc),
    .rd_loud (st_loud),
    .rd_last (st_last),
    .wr      (wr),
    .wr_idx  (idx_r),
    .wr_dc   (dc_r),
    .wr_loud (pole_res),
    .wr_time (time_r)
  );

  // ---------------- shared filter unit ----------------
  // DC tracker uses it in S_DC, the envelope in S_ENV
  assign pole_load = (state_r == S_DC) || (state_r == S_ENV);
  assign pole_x    = (state_r == S_ENV) ? rect_r : raw_r;
  assign pole_y    = (state_r == S_ENV) ? loud_r : dc_r;
  assign pole_rate = (state_r == S_ENV) ? env_rate_r : dc_rate_r;

  dhed_pole_unit #(
    .LW (LW)
  ) u_pole (
    .clk  (clk),
    .load (pole_load),
    .x    (pole_x),
    .y    (pole_y),
    .rate (pole_rate),
    .res  (pole_res)
  );

  // hit test on the freshly updated envelope; both compares strictly greater
  assign hit_nxt = force_r ||
                   ((CW'(pole_res) > CW'({thr_r, {FRAC_BITS{1'b0}}})) &&
                    ((time_r - last_r) > TIME_BITS'(refr_r)));

  assign wr.we  = (state_r == S_ENVU);
  assign wr.hit = hit_nxt;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_chok ? S_DC : S_DONE;
        end
      end
      S_DC:   state_nxt = S_DCU;
      S_DCU:  state_nxt = S_ENV;
      S_ENV:  state_nxt = S_ENVU;
      S_ENVU: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          drum_r  <= in_ch.drum;
          idx_r   <= in_idx;
          chok_r  <= in_chok;
          raw_r   <= {in_ch.sample, {FRAC_BITS{1'b0}}};
          time_r  <= in_ch.time_ms;
          force_r <= in_ch.force_hit;
          dc_r    <= st_dc;
          loud_r  <= in_chok ? st_loud : '0;   // ignored channel reports zero
          last_r  <= st_last;
          thr_r   <= setting_r[in_idx][THR_BITS-1:0];
          refr_r  <= setting_r[in_idx][SETTING_BITS-1:THR_BITS];
          hit_r   <= 1'b0;
        end
      end
      S_DCU: begin
        dc_r   <= pole_res;
        rect_r <= (raw_r >= pole_res) ? (raw_r - pole_res) : (pole_res - raw_r);
      end
      S_ENVU: begin
        loud_r <= pole_res;
        hit_r  <= hit_nxt;
      end
      default: begin
      end
    endcase
  end

  // ---------------- result register ----------------
  assign loud_ext = CW'(loud_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drum_r <= drum_r;
      out_env_r  <= loud_ext[FRAC_BITS+ENV_OUT_BITS-1:FRAC_BITS];
      out_hit_r  <= hit_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drum_out       = out_drum_r;
  assign out_ch.envelope_level = out_env_r;
  assign out_ch.hit            = out_hit_r;

`ifndef SYNTHESIS
  // only one item in flight: an accepted transfer closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input ready while an item is in work");

  // state is never written for a channel outside DRUM_COUNT
  a_wb_valid_chan: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> chok_r)
    else $error("write-back for an ignored channel");

  // forced item on a live channel always reports a hit
  a_force_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && chok_r && force_r) |=> (out_ch.valid && out_ch.hit))
    else $error("forced hit lost");

  // ignored channel gives a zero result
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !chok_r) |=> (out_ch.envelope_level == '0 && !out_ch.hit))
    else $error("ignored channel produced a nonzero result");
`endif

endmodule
